// ----- design/vqs_pkg.sv -----
// Package for the VQS transform unit: lane geometry, payload structs, register indexes.
package vqs_pkg;
	localparam int LANE_WIDTH = 16;
	localparam int VFRAC = LANE_WIDTH - 8;
	localparam int QFRAC = LANE_WIDTH - 2;
	localparam int VEC_W = 48;
	localparam int QUAT_W = 64;
	localparam int CFG_W = 64;
	localparam int IDX_W = 2;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [IDX_W-1:0] REG_TRANSLATION = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROTATION = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;

	localparam logic [VEC_W-1:0] TRANSLATION_RST = '0;
	localparam logic [QUAT_W-1:0] ROTATION_RST = QUAT_W'(1) << (QFRAC + 3 * LANE_WIDTH);
	localparam logic [VEC_W-1:0] SCALE_RST = (VEC_W'(1) << VFRAC)
		| (VEC_W'(1) << (VFRAC + LANE_WIDTH)) | (VEC_W'(1) << (VFRAC + 2 * LANE_WIDTH));

	typedef logic signed [LANE_WIDTH-1:0] lane_t;

	typedef struct packed {
		logic func;
		logic [VEC_W-1:0] vector_in;
		logic [QUAT_W-1:0] other_rotation;
		logic [VEC_W-1:0] other_scale;
	} in_beat_t;

	typedef struct packed {
		logic [VEC_W-1:0] vector_out;
		logic [QUAT_W-1:0] rotation_out;
		logic [VEC_W-1:0] scale_out;
	} out_beat_t;

	// front-to-back queue control
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	function automatic lane_t sat_lane(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (LANE_WIDTH - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) return lane_t'(hi);
		if (x < lo) return lane_t'(lo);
		return lane_t'(x);
	endfunction

	// floor((x + half) / 2^n), n >= 1
	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
		logic signed [63:0] y;
		y = x + (64'sd1 <<< (n - 1));
		return y >>> n;
	endfunction

	function automatic lane_t lane_of(input logic [QUAT_W-1:0] w, input int k);
		return lane_t'(w[k*LANE_WIDTH +: LANE_WIDTH]);
	endfunction
endpackage

// ----- design/vqs_front.sv -----
// Front end: captures accepted items into a short queue.
module vqs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vqs_pkg::in_beat_t  item,
	input  logic               pop,
	output logic               busy,
	output logic               q_valid,
	output vqs_pkg::in_beat_t  q_head
);
	vqs_pkg::in_beat_t mem_q [vqs_pkg::QDEPTH];
	logic [vqs_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [vqs_pkg::QPTR_W:0] cnt_q;
	vqs_pkg::q_ctl_t ctl;

	assign busy = (cnt_q == (vqs_pkg::QPTR_W+1)'(vqs_pkg::QDEPTH));
	assign ctl.push = start && !busy;
	assign ctl.pop = pop && q_valid;
	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (ctl.push) mem_q[wr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.push) wr_q <= wr_q + 1'b1;
			if (ctl.pop) rd_q <= rd_q + 1'b1;
			case ({ctl.push, ctl.pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ----- design/vqs_back.sv -----
// Back end: four-stage datapath for point mapping, quaternion and scale products.
module vqs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  vqs_pkg::in_beat_t            item,
	input  logic [vqs_pkg::VEC_W-1:0]    trans,
	input  logic [vqs_pkg::QUAT_W-1:0]   rot,
	input  logic [vqs_pkg::VEC_W-1:0]    scl,
	output logic                         done,
	output vqs_pkg::out_beat_t           result
);
	localparam int L = vqs_pkg::LANE_WIDTH;
	localparam int G = vqs_pkg::QFRAC;

	// stage 1: scaled point, raw quaternion products, scale product
	logic v_s1, f_s1;
	logic signed [L-1:0] sv_s1 [3];
	logic signed [L-1:0] sc_s1 [3];
	logic signed [63:0] hp_s1 [16];
	// stage 2: uv, rounded quaternion product
	logic v_s2, f_s2;
	logic signed [L-1:0] sv_s2 [3];
	logic signed [2*L+1:0] uv_s2 [3];
	logic [vqs_pkg::QUAT_W-1:0] ro_s2;
	logic [vqs_pkg::VEC_W-1:0] so_s2;
	// stage 3: uuv and w*uv
	logic v_s3, f_s3;
	logic signed [L-1:0] sv_s3 [3];
	logic signed [63:0] acc_s3 [3];
	logic [vqs_pkg::QUAT_W-1:0] ro_s3;
	logic [vqs_pkg::VEC_W-1:0] so_s3;
	logic done_q;
	vqs_pkg::out_beat_t res_q;

	logic signed [L-1:0] u [3];
	logic signed [L-1:0] w;
	always_comb begin
		for (int i = 0; i < 3; i++) u[i] = vqs_pkg::lane_of(rot, i);
		w = vqs_pkg::lane_of(rot, 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [L-1:0] a [4];
		logic signed [L-1:0] b [4];
		for (int i = 0; i < 4; i++) begin
			a[i] = vqs_pkg::lane_of(rot, i);
			b[i] = vqs_pkg::lane_of(item.other_rotation, i);
		end
		f_s1 <= item.func;
		for (int i = 0; i < 3; i++) begin
			sv_s1[i] <= vqs_pkg::sat_lane(vqs_pkg::rnd(64'(vqs_pkg::lane_of({16'd0, scl}, i))
				* 64'(vqs_pkg::lane_of({16'd0, item.vector_in}, i)), vqs_pkg::VFRAC));
			sc_s1[i] <= vqs_pkg::sat_lane(vqs_pkg::rnd(64'(vqs_pkg::lane_of({16'd0, scl}, i))
				* 64'(vqs_pkg::lane_of({16'd0, item.other_scale}, i)), vqs_pkg::VFRAC));
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				hp_s1[i*4+j] <= 64'(a[i]) * 64'(b[j]);
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] r [4];
		// index = a*4+b, lanes x0 y1 z2 w3
		r[0] = hp_s1[12] + hp_s1[3] + hp_s1[6] - hp_s1[9];
		r[1] = hp_s1[13] - hp_s1[2] + hp_s1[7] + hp_s1[8];
		r[2] = hp_s1[14] + hp_s1[1] - hp_s1[4] + hp_s1[11];
		r[3] = hp_s1[15] - hp_s1[0] - hp_s1[5] - hp_s1[10];
		f_s2 <= f_s1;
		sv_s2 <= sv_s1;
		for (int i = 0; i < 4; i++)
			ro_s2[i*L +: L] <= vqs_pkg::sat_lane(vqs_pkg::rnd(r[i], G));
		so_s2 <= {sc_s1[2], sc_s1[1], sc_s1[0]};
		uv_s2[0] <= (2*L+2)'(u[1] * sv_s1[2]) - (2*L+2)'(u[2] * sv_s1[1]);
		uv_s2[1] <= (2*L+2)'(u[2] * sv_s1[0]) - (2*L+2)'(u[0] * sv_s1[2]);
		uv_s2[2] <= (2*L+2)'(u[0] * sv_s1[1]) - (2*L+2)'(u[1] * sv_s1[0]);
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] uuv [3];
		uuv[0] = 64'(u[1]) * 64'(uv_s2[2]) - 64'(u[2]) * 64'(uv_s2[1]);
		uuv[1] = 64'(u[2]) * 64'(uv_s2[0]) - 64'(u[0]) * 64'(uv_s2[2]);
		uuv[2] = 64'(u[0]) * 64'(uv_s2[1]) - 64'(u[1]) * 64'(uv_s2[0]);
		f_s3 <= f_s2;
		sv_s3 <= sv_s2;
		ro_s3 <= ro_s2;
		so_s3 <= so_s2;
		for (int i = 0; i < 3; i++)
			acc_s3[i] <= 64'sd2 * (64'(w) * 64'(uv_s2[i]) + uuv[i]);
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] t;
		for (int i = 0; i < 3; i++) begin
			t = vqs_pkg::rnd((64'(sv_s3[i]) <<< (2*G)) + acc_s3[i], 2*G)
				+ 64'(vqs_pkg::lane_of({16'd0, trans}, i));
			res_q.vector_out[i*L +: L] <= vqs_pkg::sat_lane(t);
		end
		res_q.rotation_out <= f_s3 ? ro_s3 : '0;
		res_q.scale_out <= f_s3 ? so_s3 : '0;
	end

	assign done = done_q;
	assign result = res_q;
endmodule

// ----- design/vqs_transform_unit.sv -----
// Top level of the VQS transform unit: registers, front queue and back datapath.
// Usage:
//  Write translation (0), rotation (1) and scale (2) through cfg_we/cfg_idx/cfg_data
//  while idle; other indexes are ignored.
//  An item is accepted when start is high and busy low. Each item gives one
//  result beat: done is high for one cycle with the result on result.
//  From accept to done an item passes through the front queue, then through the
//  four back datapath stages (multipliers registered each stage).
//  Throughput is one item per cycle; the back end pops the queue every cycle,
//  so busy only rises if the queue were full, which it never is in steady use.
//  Reset loads identity transform and empties queue and pipeline.
//  The receiver cannot stall: results are offered once.
module vqs_transform_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  vqs_pkg::in_beat_t           item,
	output logic                        done,
	output vqs_pkg::out_beat_t          result,
	input  logic                        cfg_we,
	input  logic [vqs_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [vqs_pkg::CFG_W-1:0]   cfg_data
);
	logic [vqs_pkg::VEC_W-1:0] trans_q, scl_q;
	logic [vqs_pkg::QUAT_W-1:0] rot_q;
	logic q_valid;
	vqs_pkg::in_beat_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= vqs_pkg::TRANSLATION_RST;
			rot_q <= vqs_pkg::ROTATION_RST;
			scl_q <= vqs_pkg::SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				vqs_pkg::REG_TRANSLATION: trans_q <= cfg_data[vqs_pkg::VEC_W-1:0];
				vqs_pkg::REG_ROTATION: rot_q <= cfg_data;
				vqs_pkg::REG_SCALE: scl_q <= cfg_data[vqs_pkg::VEC_W-1:0];
				default: ;
			endcase
		end
	end

	vqs_front u_front (
		.clk, .arst_n, .start, .item, .pop(1'b1), .busy, .q_valid, .q_head
	);

	vqs_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .item(q_head),
		.trans(trans_q), .rot(rot_q), .scl(scl_q), .done, .result
	);
endmodule

// ----- design/vqs_checker.sv -----
// Port-level checker for the VQS transform unit, bound to the top level.
module vqs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input vqs_pkg::out_beat_t result,
	input vqs_pkg::in_beat_t  item
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done) else $error("missing result beat");
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5)) else $error("spurious result beat");
	a_mode0: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.func) |-> ##5 (result.rotation_out == '0
		&& result.scale_out == '0)) else $error("mode 0 extra fields nonzero");
	a_free: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled");
endmodule

bind vqs_transform_unit vqs_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .result, .item
);

// ----- tb/vqs_transform_unit_tb.sv -----
// Self-checking testbench for vqs_transform_unit: directed table, then randomized config phases.
module vqs_transform_unit_tb;
	localparam logic [vqs_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 160;
	localparam int NUM_PHASES = 12;

	typedef struct {
		bit has_want;
		vqs_pkg::in_beat_t stim;
		vqs_pkg::out_beat_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	vqs_pkg::in_beat_t item;
	logic done;
	vqs_pkg::out_beat_t result;
	logic cfg_we;
	logic [vqs_pkg::IDX_W-1:0] cfg_idx;
	logic [vqs_pkg::CFG_W-1:0] cfg_data;

	// local copy of the held transform
	logic [vqs_pkg::VEC_W-1:0] xf_trans;
	logic [vqs_pkg::QUAT_W-1:0] xf_rot;
	logic [vqs_pkg::VEC_W-1:0] xf_scale;

	vqs_pkg::out_beat_t pending_q[$];
	int errors;
	int idle_cycles;
	int burst_left;

	vqs_transform_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint lane_val(input logic [63:0] w, input int k);
		logic signed [vqs_pkg::LANE_WIDTH-1:0] l;
		l = w[k*vqs_pkg::LANE_WIDTH +: vqs_pkg::LANE_WIDTH];
		return longint'(l);
	endfunction

	function automatic logic [vqs_pkg::LANE_WIDTH-1:0] clamp_lane(input longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) << (vqs_pkg::LANE_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) return hi[vqs_pkg::LANE_WIDTH-1:0];
		if (x < lo) return lo[vqs_pkg::LANE_WIDTH-1:0];
		return x[vqs_pkg::LANE_WIDTH-1:0];
	endfunction

	// round half up, then floor
	function automatic longint round_down(input longint x, input int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic logic [vqs_pkg::VEC_W-1:0] mul_lanes(input logic [vqs_pkg::VEC_W-1:0] a,
			input logic [vqs_pkg::VEC_W-1:0] b);
		logic [vqs_pkg::VEC_W-1:0] r;
		r = '0;
		for (int i = 0; i < 3; i++)
			r[i*vqs_pkg::LANE_WIDTH +: vqs_pkg::LANE_WIDTH] =
				clamp_lane(round_down(lane_val({16'd0, a}, i) * lane_val({16'd0, b}, i),
					vqs_pkg::VFRAC));
		return r;
	endfunction

	function automatic vqs_pkg::out_beat_t transform_item(input vqs_pkg::in_beat_t b);
		vqs_pkg::out_beat_t r;
		logic [vqs_pkg::VEC_W-1:0] svw;
		longint sv[3], u[3], uv[3], uuv[3];
		longint w, acc;
		r = '0;
		svw = mul_lanes(xf_scale, b.vector_in);
		w = lane_val(xf_rot, 3);
		for (int i = 0; i < 3; i++) begin
			sv[i] = lane_val({16'd0, svw}, i);
			u[i] = lane_val(xf_rot, i);
		end
		uv[0] = u[1] * sv[2] - u[2] * sv[1];
		uv[1] = u[2] * sv[0] - u[0] * sv[2];
		uv[2] = u[0] * sv[1] - u[1] * sv[0];
		uuv[0] = u[1] * uv[2] - u[2] * uv[1];
		uuv[1] = u[2] * uv[0] - u[0] * uv[2];
		uuv[2] = u[0] * uv[1] - u[1] * uv[0];
		for (int i = 0; i < 3; i++) begin
			acc = (sv[i] <<< (2 * vqs_pkg::QFRAC)) + 2 * (w * uv[i] + uuv[i]);
			r.vector_out[i*vqs_pkg::LANE_WIDTH +: vqs_pkg::LANE_WIDTH] =
				clamp_lane(round_down(acc, 2 * vqs_pkg::QFRAC)
					+ lane_val({16'd0, xf_trans}, i));
		end
		if (b.func) begin
			longint ax, ay, az, aw, bx, by, bz, bw;
			longint h[4];
			ax = lane_val(xf_rot, 0); ay = lane_val(xf_rot, 1);
			az = lane_val(xf_rot, 2); aw = lane_val(xf_rot, 3);
			bx = lane_val(b.other_rotation, 0); by = lane_val(b.other_rotation, 1);
			bz = lane_val(b.other_rotation, 2); bw = lane_val(b.other_rotation, 3);
			h[0] = aw * bx + ax * bw + ay * bz - az * by;
			h[1] = aw * by - ax * bz + ay * bw + az * bx;
			h[2] = aw * bz + ax * by - ay * bx + az * bw;
			h[3] = aw * bw - ax * bx - ay * by - az * bz;
			for (int i = 0; i < 4; i++)
				r.rotation_out[i*vqs_pkg::LANE_WIDTH +: vqs_pkg::LANE_WIDTH] =
					clamp_lane(round_down(h[i], vqs_pkg::QFRAC));
			r.scale_out = mul_lanes(xf_scale, b.other_scale);
		end
		return r;
	endfunction

	// lanes biased toward the corners of the range
	function automatic logic [63:0] pick_lanes();
		logic [63:0] v;
		for (int i = 0; i < 4; i++)
			case ($urandom_range(0, 9))
				0: v[i*16 +: 16] = 16'h7fff;
				1: v[i*16 +: 16] = 16'h8000;
				2: v[i*16 +: 16] = 16'h0000;
				3: v[i*16 +: 16] = 16'hffff;
				4: v[i*16 +: 16] = 16'h0100;
				default: v[i*16 +: 16] = 16'($urandom);
			endcase
		return v;
	endfunction

	task automatic write_reg(input logic [vqs_pkg::IDX_W-1:0] idx,
			input logic [vqs_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vqs_pkg::REG_TRANSLATION: xf_trans = data[vqs_pkg::VEC_W-1:0];
			vqs_pkg::REG_ROTATION: xf_rot = data;
			vqs_pkg::REG_SCALE: xf_scale = data[vqs_pkg::VEC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_item(input vqs_pkg::in_beat_t b, input bit has_want,
			input vqs_pkg::out_beat_t want);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= b;
		// busy is steady from the falling edge to the accepting rising edge
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_q.push_back(has_want ? want : transform_item(b));
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		vqs_pkg::in_beat_t b;
		for (int n = 0; n < count; n++) begin
			b.func = 1'($urandom_range(0, 1));
			b.vector_in = vqs_pkg::VEC_W'(pick_lanes());
			b.other_rotation = pick_lanes();
			b.other_scale = vqs_pkg::VEC_W'(pick_lanes());
			send_item(b, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vqs_transform_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", result);
			end else begin
				vqs_pkg::out_beat_t exp_beat;
				exp_beat = pending_q.pop_front();
				if (result.vector_out !== exp_beat.vector_out
						|| result.rotation_out !== exp_beat.rotation_out
						|| result.scale_out !== exp_beat.scale_out) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: vec %h/%h rot %h/%h scale %h/%h (exp/got)",
							exp_beat.vector_out, result.vector_out,
							exp_beat.rotation_out, result.rotation_out,
							exp_beat.scale_out, result.scale_out);
				end
			end
		end
	end

	initial begin
		dir_row_t dir_tab[$];
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = vqs_pkg::REG_TRANSLATION;
		cfg_data = '0;
		xf_trans = vqs_pkg::TRANSLATION_RST;
		xf_rot = vqs_pkg::ROTATION_RST;
		xf_scale = vqs_pkg::SCALE_RST;

		// identity transform out of reset: points pass through, compose returns the operand
		dir_tab = '{
			'{1, '{1'b0, 48'h0, 64'h0, 48'h0}, '{48'h0, 64'h0, 48'h0}},
			'{1, '{1'b0, 48'h7fff7fff7fff, '1, '1}, '{48'h7fff7fff7fff, 64'h0, 48'h0}},
			'{1, '{1'b0, 48'h800080008000, '1, '1}, '{48'h800080008000, 64'h0, 48'h0}},
			'{1, '{1'b0, 48'h0001ffff8001, 64'h0, 48'h0}, '{48'h0001ffff8001, 64'h0, 48'h0}},
			'{1, '{1'b1, 48'h123456789abc, 64'h4000000000000000, 48'h010001000100},
				'{48'h123456789abc, 64'h4000000000000000, 48'h010001000100}},
			'{1, '{1'b1, 48'h7fff80007fff, 64'h7fff80007fff8000, 48'h80007fff8000},
				'{48'h7fff80007fff, 64'h7fff80007fff8000, 48'h80007fff8000}},
			'{1, '{1'b1, '1, '1, '1}, '{'1, '1, '1}},
			'{1, '{1'b1, 48'h0, 64'h0, 48'h0}, '{48'h0, 64'h0, 48'h0}}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) send_item(dir_tab[i].stim, dir_tab[i].has_want, dir_tab[i].want);
		drain();
		// unmapped index must leave the identity in place
		write_reg(REG_UNUSED, '1);
		send_item(dir_tab[4].stim, 1'b1, dir_tab[4].want);
		drain();

		// saturating corners of the held transform
		write_reg(vqs_pkg::REG_TRANSLATION, 64'h7fff7fff7fff);
		write_reg(vqs_pkg::REG_ROTATION, 64'h7fff7fff7fff7fff);
		write_reg(vqs_pkg::REG_SCALE, 64'h7fff7fff7fff);
		foreach (dir_tab[i]) send_item(dir_tab[i].stim, 1'b0, '0);
		drain();
		write_reg(vqs_pkg::REG_TRANSLATION, 64'h800080008000);
		write_reg(vqs_pkg::REG_ROTATION, 64'h8000800080008000);
		write_reg(vqs_pkg::REG_SCALE, 64'h800080008000);
		foreach (dir_tab[i]) send_item(dir_tab[i].stim, 1'b0, '0);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					write_reg(vqs_pkg::REG_TRANSLATION, '0);
					write_reg(vqs_pkg::REG_ROTATION, '0);
					write_reg(vqs_pkg::REG_SCALE, '0);
				end
				1: begin
					write_reg(vqs_pkg::REG_TRANSLATION, '1);
					write_reg(vqs_pkg::REG_ROTATION, '1);
					write_reg(vqs_pkg::REG_SCALE, '1);
				end
				2: begin
					write_reg(vqs_pkg::REG_TRANSLATION, 64'h7fff7fff7fff);
					write_reg(vqs_pkg::REG_ROTATION, 64'h7fff7fff7fff7fff);
					write_reg(vqs_pkg::REG_SCALE, 64'h7fff7fff7fff);
				end
				3: begin
					write_reg(vqs_pkg::REG_TRANSLATION,
						vqs_pkg::CFG_W'(vqs_pkg::TRANSLATION_RST));
					write_reg(vqs_pkg::REG_ROTATION, vqs_pkg::ROTATION_RST);
					write_reg(vqs_pkg::REG_SCALE, vqs_pkg::CFG_W'(vqs_pkg::SCALE_RST));
				end
				4: begin
					// 90 degrees about z, roughly unit
					write_reg(vqs_pkg::REG_TRANSLATION, 64'h00000100ff00);
					write_reg(vqs_pkg::REG_ROTATION, 64'h2d412d4100000000);
					write_reg(vqs_pkg::REG_SCALE, 64'h020001800080);
				end
				default: begin
					write_reg(vqs_pkg::REG_TRANSLATION, pick_lanes());
					write_reg(vqs_pkg::REG_ROTATION, pick_lanes());
					write_reg(vqs_pkg::REG_SCALE, pick_lanes());
					if ($urandom_range(0, 1)) write_reg(REG_UNUSED, {$urandom, $urandom});
				end
			endcase
			send_random(PHASE_ITEMS);
			drain();
		end

		if (errors == 0) begin
			$display("vqs_transform_unit regression: pass");
		end else begin
			$display("vqs_transform_unit regression: fail");
		end
		$finish;
	end
endmodule

// ----- vqs_transform_unit.f -----
design/vqs_pkg.sv
design/vqs_front.sv
design/vqs_back.sv
design/vqs_transform_unit.sv
design/vqs_checker.sv
tb/vqs_transform_unit_tb.sv
